// File: rtl/core/dnp_pkg.sv
// Package for the dotted-name to wire-format parser.
// Types and constants shared by the evaluation logic and the top level.
// No dependencies.
`timescale 1ns / 1ps

package dnp_pkg;

  localparam int MAX_LABEL = 63;
  localparam int MAX_NAME  = 255;

  // Results one text item can cause, and the counter width to hold that many.
  localparam int RES_MAX   = 4;
  localparam int RES_CNT_W = $clog2(RES_MAX + 1);

  // Special characters of the name text
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  // Escape decoder state
  localparam logic [1:0] ESC_NORMAL = 2'd0;
  localparam logic [1:0] ESC_SLASH  = 2'd1;
  localparam logic [1:0] ESC_OCT1   = 2'd2;
  localparam logic [1:0] ESC_OCT2   = 2'd3;

  typedef struct packed {
    logic [1:0] esc;
    logic [7:0] pend;
    logic [7:0] name_len;
    logic [5:0] label_len;
    logic       err;
  } dnp_state_t;

  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] data;
    logic       done;
    logic       ok;
  } dnp_res_t;

  // One label operation: updated state plus an optional write
  typedef struct packed {
    dnp_state_t st;
    logic       push;
    dnp_res_t   res;
  } dnp_op_t;

endpackage

// File: rtl/core/dnp_channels_if.sv
// Valid/ready channel interfaces of the dotted-name parser.
// Text-byte input channel and wire-write result channel; no dependencies.
`timescale 1ns / 1ps

interface dnp_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, has_byte, text_byte, end_of_text, input ready);
  modport sink   (input valid, has_byte, text_byte, end_of_text, output ready);
endinterface

interface dnp_out_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [7:0] wire_address;
  logic [7:0] wire_byte;
  logic       name_done;
  logic       status_ok;
  logic       last_of_run;

  modport source (output valid, write_enable, wire_address, wire_byte, name_done,
                  status_ok, last_of_run, input ready);
  modport sink   (input valid, write_enable, wire_address, wire_byte, name_done,
                  status_ok, last_of_run, output ready);
endinterface

// File: rtl/core/dnp_eval.sv
// Combinational evaluation of one text item against the parser state.
// Produces up to RES_MAX results (wire writes or an error report) and the next state; uses dnp_pkg.
`timescale 1ns / 1ps

module dnp_eval
  import dnp_pkg::*;
(
  input  dnp_state_t                 st,
  input  logic                       has_byte,
  input  logic [7:0]                 text_byte,
  input  logic                       end_of_text,
  output dnp_state_t                 st_nxt,
  output dnp_res_t [RES_MAX-1:0]     res,
  output logic [RES_CNT_W-1:0]       res_cnt
);

  function automatic dnp_op_t nop_op(dnp_state_t s);
    dnp_op_t o;
    o.st   = s;
    o.push = 1'b0;
    o.res  = '0;
    return o;
  endfunction

  function automatic dnp_op_t add_byte(dnp_state_t s, logic [7:0] c);
    dnp_op_t    o;
    logic [8:0] addr;
    o    = nop_op(s);
    addr = {1'b0, s.name_len} + 9'd1 + {3'b000, s.label_len};
    if (!s.err) begin
      if (s.label_len >= 6'(MAX_LABEL)) begin
        o.st.err = 1'b1;
      end else if (addr > 9'(MAX_NAME - 2)) begin
        o.st.err = 1'b1;
      end else begin
        o.push         = 1'b1;
        o.res.we       = 1'b1;
        o.res.addr     = addr[7:0];
        o.res.data     = c;
        o.st.label_len = s.label_len + 6'd1;
      end
    end
    return o;
  endfunction

  function automatic dnp_op_t close_label(dnp_state_t s);
    dnp_op_t o;
    o = nop_op(s);
    if (!s.err && s.label_len != 6'd0) begin
      o.push         = 1'b1;
      o.res.we       = 1'b1;
      o.res.addr     = s.name_len;
      o.res.data     = {2'b00, s.label_len};
      o.st.name_len  = s.name_len + 8'd1 + {2'b00, s.label_len};
      o.st.label_len = 6'd0;
    end
    return o;
  endfunction

  always_comb begin
    dnp_state_t            s;
    dnp_op_t               o;
    dnp_res_t [RES_MAX-1:0] r;
    logic [RES_CNT_W-1:0]  n;
    logic                  oct;
    logic                  add1;
    logic [7:0]            add1_c;
    logic                  nrm;

    s      = st;
    r      = '0;
    n      = '0;
    oct    = (text_byte >= CH_ZERO) && (text_byte <= CH_SEVEN);
    add1   = 1'b0;
    add1_c = text_byte;
    nrm    = 1'b0;

    // escape decode
    if (has_byte) begin
      unique case (s.esc) inside
        ESC_SLASH: begin
          if (oct) begin
            s.pend = {5'b00000, text_byte[2:0]};
            s.esc  = ESC_OCT1;
          end else begin
            s.esc = ESC_NORMAL;
            add1  = 1'b1;
          end
        end
        ESC_OCT1, ESC_OCT2: begin
          if (oct) begin
            // (pend << 3) + digit, kept to 8 bits
            s.pend = {s.pend[4:0], text_byte[2:0]};
            if (s.esc == ESC_OCT1) begin
              s.esc = ESC_OCT2;
            end else begin
              s.esc  = ESC_NORMAL;
              add1   = 1'b1;
              add1_c = s.pend;
            end
          end else begin
            s.esc  = ESC_NORMAL;
            add1   = 1'b1;
            add1_c = s.pend;
            nrm    = 1'b1;
          end
        end
        default: nrm = 1'b1;
      endcase
    end

    // escaped or octal byte
    o = add1 ? add_byte(s, add1_c) : nop_op(s);
    s = o.st;
    if (o.push) begin
      r[n[1:0]] = o.res;
      n         = n + 1'b1;
    end

    // plain character
    o = nop_op(s);
    if (nrm) begin
      if (text_byte == CH_DOT) begin
        o = close_label(s);
      end else if (text_byte == CH_BSLASH) begin
        o.st.esc = ESC_SLASH;
      end else begin
        o = add_byte(s, text_byte);
      end
    end
    s = o.st;
    if (o.push) begin
      r[n[1:0]] = o.res;
      n         = n + 1'b1;
    end

    // end of text: flush an open octal escape
    o = (end_of_text && s.esc[1]) ? add_byte(s, s.pend) : nop_op(s);
    s = o.st;
    if (o.push) begin
      r[n[1:0]] = o.res;
      n         = n + 1'b1;
    end

    // end of text: close the last label
    o = end_of_text ? close_label(s) : nop_op(s);
    s = o.st;
    if (o.push) begin
      r[n[1:0]] = o.res;
      n         = n + 1'b1;
    end

    // end of text: terminator or error report, then back to reset state
    if (end_of_text) begin
      r[n[1:0]].we   = !s.err;
      r[n[1:0]].addr = s.err ? 8'd0 : s.name_len;
      r[n[1:0]].data = 8'd0;
      r[n[1:0]].done = 1'b1;
      r[n[1:0]].ok   = !s.err;
      n              = n + 1'b1;
      s              = '0;
    end

    st_nxt  = s;
    res     = r;
    res_cnt = n;
  end

endmodule

// File: rtl/core/dotted_name_to_wire_parser_core.sv
// Top level of the dotted DNS name to wire-format parser.
// Uses dnp_pkg, dnp_in_if / dnp_out_if (dnp_channels_if.sv) and dnp_eval.
`timescale 1ns / 1ps

// Takes the text of a dotted DNS name one byte per transfer and emits the
// wire-format name as addressed byte writes. Label bytes are written at their
// final offset as they arrive; the length byte is written back at the label's
// start when a dot or the end of text closes it. The item flagged end_of_text
// also yields the final result: the zero terminator with status_ok 1, or, after
// a label over 63 bytes or a name over 255 bytes, a no-write result with
// status_ok 0. Backslash escapes, including one to three octal digits, are
// decoded. Timing: an accepted item sits in an input register, is evaluated in
// one combinational pass and its results are loaded into a four-entry result
// buffer, whose head is the result shown on the output. An item that yields
// zero or one result leaves the input free for the next, so plain text runs
// at one byte per cycle while the result channel is not stalled; an item
// yielding several results (at most four) holds the result buffer, and thus
// the input, until its last result is taken. The parse state advances when
// an item moves from the input register into the result buffer.
module dotted_name_to_wire_parser_core
  import dnp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  dnp_in_if.sink          in_ch,
  dnp_out_if.source       out_ch
);

  // input register
  logic                   in_v_r;
  logic                   has_r;
  logic [7:0]             byte_r;
  logic                   eot_r;

  // parse state
  dnp_state_t             st_r;
  dnp_state_t             st_nxt;

  // evaluation results
  dnp_res_t [RES_MAX-1:0] ev_res;
  logic [RES_CNT_W-1:0]   ev_cnt;

  // result buffer, head at entry 0
  dnp_res_t [RES_MAX-1:0] buf_r;
  dnp_res_t [RES_MAX-1:0] buf_nxt;
  logic [RES_CNT_W-1:0]   cnt_r;
  logic [RES_CNT_W-1:0]   cnt_nxt;

  logic                   pop;
  logic                   can_load;
  logic                   consume;
  logic                   accept;

  dnp_eval u_eval (
    .st          (st_r),
    .has_byte    (has_r),
    .text_byte   (byte_r),
    .end_of_text (eot_r),
    .st_nxt      (st_nxt),
    .res         (ev_res),
    .res_cnt     (ev_cnt)
  );

  // Buffer may take a new run when empty, or when its last entry leaves now.
  assign pop      = (cnt_r != '0) && out_ch.ready;
  assign can_load = (cnt_r == '0) || ((cnt_r == RES_CNT_W'(1)) && out_ch.ready);
  assign consume  = in_v_r && can_load;
  assign in_ch.ready = !in_v_r || consume;
  assign accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (consume) begin
      buf_nxt = ev_res;
      cnt_nxt = ev_cnt;
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      cnt_r  <= '0;
      st_r   <= '0;
    end else begin
      if (accept) begin
        in_v_r <= 1'b1;
      end else if (consume) begin
        in_v_r <= 1'b0;
      end
      cnt_r <= cnt_nxt;
      if (consume) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      has_r  <= in_ch.has_byte;
      byte_r <= in_ch.text_byte;
      eot_r  <= in_ch.end_of_text;
    end
    buf_r <= buf_nxt;
  end

  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.write_enable = buf_r[0].we;
  assign out_ch.wire_address = buf_r[0].addr;
  assign out_ch.wire_byte    = buf_r[0].data;
  assign out_ch.name_done    = buf_r[0].done;
  assign out_ch.status_ok    = buf_r[0].ok;
  assign out_ch.last_of_run  = (cnt_r == RES_CNT_W'(1));

endmodule

// File: rtl/core/dnp_checker.sv
// Port-level checker for the dotted-name parser, with its bind statement.
// Watches the result channel of dotted_name_to_wire_parser_core.
`timescale 1ns / 1ps

module dnp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_we,
  input logic [7:0] out_addr,
  input logic [7:0] out_byte,
  input logic       out_done,
  input logic       out_ok,
  input logic       out_last
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_we, out_addr, out_byte, out_done, out_ok, out_last}))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> out_last)
    else $error("name end not last of its run");

  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> (out_ok == out_we) && (out_we || out_addr == 8'd0))
    else $error("final result status does not match its write");

  a_mid_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done |-> out_we && !out_ok)
    else $error("label result without write or with status set");

endmodule

bind dotted_name_to_wire_parser_core dnp_checker u_dnp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_we    (out_ch.write_enable),
  .out_addr  (out_ch.wire_address),
  .out_byte  (out_ch.wire_byte),
  .out_done  (out_ch.name_done),
  .out_ok    (out_ch.status_ok),
  .out_last  (out_ch.last_of_run)
);
